// ===== hdl/safs_pkg.sv =====
// shared types, opcodes, register indexes and heading tables for the sprite frame sequencer
// used by safs_cfg, safs_div and sprite_animation_frame_sequencer_unit; no dependencies

package safs_pkg;

    // sizing limits of the frame store
    localparam int unsigned MAX_FRAMES     = 1024;
    localparam int unsigned MAX_DIRECTIONS = 64;

    // quotient bits produced by the shared divider
    localparam int unsigned DIV_QW = 11;

    // opcodes
    localparam logic [3:0] OP_ADVANCE         = 4'd0;
    localparam logic [3:0] OP_STEP_BACK       = 4'd1;
    localparam logic [3:0] OP_SET_FRAME       = 4'd2;
    localparam logic [3:0] OP_SET_DIR_FRAME   = 4'd3;
    localparam logic [3:0] OP_SET_DIR64_FRAME = 4'd4;
    localparam logic [3:0] OP_SET_DIR         = 4'd5;
    localparam logic [3:0] OP_SET_DIR64       = 4'd6;
    localparam logic [3:0] OP_DIR_START       = 4'd7;
    localparam logic [3:0] OP_DIR_END         = 4'd8;

    // configuration register indexes
    localparam logic [1:0] REG_TOTAL_FRAMES     = 2'd0;
    localparam logic [1:0] REG_TOTAL_DIRECTIONS = 2'd1;
    localparam logic [1:0] REG_FRAME_INTERVAL   = 2'd2;
    localparam logic [1:0] REG_SPRITE_LOADED    = 2'd3;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [31:0] now;
        logic        loop;
        logic [5:0]  direction;
        logic [9:0]  frame_value;
    } safs_in_t;

    typedef struct packed {
        logic [9:0] current_frame;
        logic [5:0] current_direction;
        logic [9:0] frame_in_direction;
        logic       at_last_frame;
        logic       flag;
    } safs_out_t;

    // effective configuration after clamping
    typedef struct packed {
        logic [10:0] eff_frames;
        logic [6:0]  eff_dirs;
        logic [31:0] interval;
        logic        loaded;
    } safs_cfg_t;

    typedef struct packed {
        logic              start;
        logic [31:0]       num_hi;
        logic [DIV_QW-1:0] num_lo;
        logic [31:0]       den;
    } safs_div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quot;
        logic [31:0]       rem;
    } safs_div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RUN,
        S_DISPATCH,
        S_MUL,
        S_PART,
        S_NDIV,
        S_QDIV,
        S_QMOD,
        S_APPLY,
        S_OUT
    } safs_state_t;

    // 64 / d for d in 1..64
    function automatic logic [6:0] quant_step(input logic [6:0] d);
        logic [6:0] s;
        if (d <= 7'd1)       s = 7'd64;
        else if (d == 7'd2)  s = 7'd32;
        else if (d == 7'd3)  s = 7'd21;
        else if (d == 7'd4)  s = 7'd16;
        else if (d == 7'd5)  s = 7'd12;
        else if (d == 7'd6)  s = 7'd10;
        else if (d == 7'd7)  s = 7'd9;
        else if (d == 7'd8)  s = 7'd8;
        else if (d == 7'd9)  s = 7'd7;
        else if (d == 7'd10) s = 7'd6;
        else if (d <= 7'd12) s = 7'd5;
        else if (d <= 7'd16) s = 7'd4;
        else if (d <= 7'd21) s = 7'd3;
        else if (d <= 7'd32) s = 7'd2;
        else                 s = 7'd1;
        return s;
    endfunction

    // 32 / d for d in 1..64
    function automatic logic [5:0] quant_half(input logic [6:0] d);
        logic [5:0] h;
        if (d <= 7'd1)       h = 6'd32;
        else if (d == 7'd2)  h = 6'd16;
        else if (d == 7'd3)  h = 6'd10;
        else if (d == 7'd4)  h = 6'd8;
        else if (d == 7'd5)  h = 6'd6;
        else if (d == 7'd6)  h = 6'd5;
        else if (d <= 7'd8)  h = 6'd4;
        else if (d <= 7'd10) h = 6'd3;
        else if (d <= 7'd16) h = 6'd2;
        else if (d <= 7'd32) h = 6'd1;
        else                 h = 6'd0;
        return h;
    endfunction

endpackage

// ===== hdl/sprite_animation_frame_sequencer_unit.sv =====
// top level of the sprite frame sequencer: item sequencer, frame state and output register
// depends on safs_pkg, safs_cfg and safs_div

// Sprite animation frame sequencer. Keeps the current frame, direction and
// animation start time of one sprite whose frames are split into equal runs,
// one run per direction. Each input item carries an opcode (advance by time,
// step back, set frame, set direction with frame, set from a 64-way heading,
// set direction, jump to run start or end) and yields exactly one result item
// with the new frame, direction, frame within the run, a last-frame mark and
// the operation's flag. One item is worked on at a time; in_ready is high only
// while the sequencer is idle, and a finished result waits in the output
// register without holding up the next item, unless the register still holds
// the result before it. All divisions go through one shared 11-step divider.
// An item passes through the run length division (frames over directions),
// then dispatch, the state update, the result hand-over and idle. An advance
// of a loaded sprite inside the interval adds a multiply state and a second
// division (run times elapsed over the interval); set frame with a frame
// value below the frame count adds one division (frame over run length); set
// direction with frame from a heading and set direction from a heading add
// two divisions (heading scaling, then the remainder by the direction count);
// every other case goes from dispatch straight to the state update.
// Configuration is written through a plain write port; the user must write it
// only while no item is in flight, and the block itself does not enforce this.

module sprite_animation_frame_sequencer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  safs_pkg::safs_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output safs_pkg::safs_out_t out_data,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import safs_pkg::*;

    safs_cfg_t     cfg;
    safs_div_req_t div_req;
    safs_div_rsp_t div_rsp;

    // sequencer
    safs_state_t state_reg, state_next;

    // latched item
    logic [3:0]  op_reg, op_next;
    logic [31:0] now_reg, now_next;
    logic        loop_reg, loop_next;
    logic [5:0]  dir_in_reg, dir_in_next;
    logic [9:0]  fv_reg, fv_next;
    logic [31:0] elapsed_reg, elapsed_next;

    // intermediate results
    logic [10:0] run_reg, run_next;
    logic [10:0] aux_reg, aux_next;
    logic [42:0] prod_reg, prod_next;

    // sprite state
    logic [9:0]  frame_reg, frame_next;
    logic [5:0]  dir_reg, dir_next;
    logic [31:0] start_time_reg, start_time_next;
    logic        flag_reg, flag_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    safs_out_t   out_data_reg, out_data_next;

    // run start and end arithmetic
    logic [5:0]  mdir;
    logic [16:0] rs;
    logic [17:0] re;
    logic        elapsed_ge;
    logic        fv_lt_f;
    logic        fv_in_run;
    logic        dir_ok;
    logic        nf_lt;
    logic [6:0]  dmax;
    logic [5:0]  nd;
    logic [9:0]  fv_part;

    safs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    safs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // direction whose run is being addressed: the target of the op while applying,
    // the (new) current direction while forming the result
    always_comb
    begin
        mdir = dir_reg;
        if (state_reg == S_APPLY)
        begin
            unique case (op_reg)
                OP_SET_DIR_FRAME, OP_SET_DIR:      mdir = dir_in_reg;
                OP_SET_DIR64_FRAME, OP_SET_DIR64:  mdir = aux_reg[5:0];
                default:                           mdir = dir_reg;
            endcase
        end

        rs = 17'(run_reg) * 17'(mdir);
        re = {1'b0, rs} + {7'b0, run_reg} - 18'd1;

        elapsed_ge = (elapsed_reg >= cfg.interval);
        fv_lt_f    = ({1'b0, fv_reg} < cfg.eff_frames);
        fv_in_run  = ({1'b0, fv_reg} < run_reg);
        dir_ok     = ({1'b0, mdir} < cfg.eff_dirs);
        // frame - 1 falls below the run start; frame 0 wraps below zero
        nf_lt      = (frame_reg == 10'd0) || ({7'b0, frame_reg - 10'd1} < rs);
        dmax       = cfg.eff_dirs - 7'd1;
        nd         = (aux_reg > {4'b0, dmax}) ? dmax[5:0] : aux_reg[5:0];
        fv_part    = fv_in_run ? fv_reg : 10'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            frame_reg      <= '0;
            dir_reg        <= '0;
            start_time_reg <= '0;
            flag_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            frame_reg      <= frame_next;
            dir_reg        <= dir_next;
            start_time_reg <= start_time_next;
            flag_reg       <= flag_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        now_reg      <= now_next;
        loop_reg     <= loop_next;
        dir_in_reg   <= dir_in_next;
        fv_reg       <= fv_next;
        elapsed_reg  <= elapsed_next;
        run_reg      <= run_next;
        aux_reg      <= aux_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        loop_next       = loop_reg;
        dir_in_next     = dir_in_reg;
        fv_next         = fv_reg;
        elapsed_next    = elapsed_reg;
        run_next        = run_reg;
        aux_next        = aux_reg;
        prod_next       = prod_reg;
        frame_next      = frame_reg;
        dir_next        = dir_reg;
        start_time_next = start_time_reg;
        flag_next       = flag_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        div_req         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = in_data.opcode;
                    now_next     = in_data.now;
                    loop_next    = in_data.loop;
                    dir_in_next  = in_data.direction;
                    fv_next      = in_data.frame_value;
                    elapsed_next = in_data.now - start_time_reg;
                    // run length = frames / directions
                    div_req.start  = 1'b1;
                    div_req.num_lo = cfg.eff_frames;
                    div_req.den    = {25'b0, cfg.eff_dirs};
                    state_next     = S_RUN;
                end
            end

            S_RUN:
            begin
                if (div_rsp.done)
                begin
                    run_next   = div_rsp.quot;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                unique case (op_reg)
                    OP_ADVANCE:
                    begin
                        if (cfg.loaded && !elapsed_ge)
                        begin
                            prod_next  = 43'(run_reg) * 43'(elapsed_reg);
                            state_next = S_MUL;
                        end
                        else
                            state_next = S_APPLY;
                    end
                    OP_SET_FRAME:
                    begin
                        if (fv_lt_f)
                        begin
                            div_req.start  = 1'b1;
                            div_req.num_lo = {1'b0, fv_reg};
                            div_req.den    = {21'b0, run_reg};
                            state_next     = S_NDIV;
                        end
                        else
                            state_next = S_APPLY;
                    end
                    OP_SET_DIR64_FRAME, OP_SET_DIR64:
                    begin
                        // heading plus half a sector, over the sector width
                        div_req.start  = 1'b1;
                        div_req.num_lo = 11'(dir_in_reg) + 11'(quant_half(cfg.eff_dirs));
                        div_req.den    = {25'b0, quant_step(cfg.eff_dirs)};
                        state_next     = S_QDIV;
                    end
                    default:
                        state_next = S_APPLY;
                endcase
            end

            S_MUL:
            begin
                // quotient stays below the run length, so the high part is below the interval
                div_req.start  = 1'b1;
                div_req.num_hi = prod_reg[42:11];
                div_req.num_lo = prod_reg[10:0];
                div_req.den    = cfg.interval;
                state_next     = S_PART;
            end

            S_PART, S_NDIV:
            begin
                if (div_rsp.done)
                begin
                    aux_next   = div_rsp.quot;
                    state_next = S_APPLY;
                end
            end

            S_QDIV:
            begin
                if (div_rsp.done)
                begin
                    // wrap the sector number into the direction count
                    div_req.start  = 1'b1;
                    div_req.num_lo = div_rsp.quot;
                    div_req.den    = {25'b0, cfg.eff_dirs};
                    state_next     = S_QMOD;
                end
            end

            S_QMOD:
            begin
                if (div_rsp.done)
                begin
                    aux_next   = {5'b0, div_rsp.rem[5:0]};
                    state_next = S_APPLY;
                end
            end

            S_APPLY:
            begin
                flag_next = 1'b0;
                unique case (op_reg)
                    OP_ADVANCE:
                    begin
                        if (cfg.loaded)
                        begin
                            flag_next = 1'b1;
                            if (elapsed_ge)
                            begin
                                if (loop_reg)
                                begin
                                    start_time_next = now_reg;
                                    frame_next      = rs[9:0];
                                end
                                else
                                    frame_next = re[9:0];
                            end
                            else
                                frame_next = rs[9:0] + aux_reg[9:0];
                        end
                    end
                    OP_STEP_BACK:
                    begin
                        if (cfg.loaded && elapsed_ge)
                        begin
                            flag_next       = 1'b1;
                            start_time_next = now_reg;
                            if (nf_lt)
                                frame_next = loop_reg ? re[9:0] : rs[9:0];
                            else
                                frame_next = frame_reg - 10'd1;
                        end
                    end
                    OP_SET_FRAME:
                    begin
                        if (fv_lt_f)
                        begin
                            flag_next       = 1'b1;
                            frame_next      = fv_reg;
                            dir_next        = nd;
                            start_time_next = now_reg;
                        end
                    end
                    OP_SET_DIR_FRAME, OP_SET_DIR64_FRAME:
                    begin
                        if (dir_ok)
                        begin
                            flag_next       = 1'b1;
                            dir_next        = mdir;
                            frame_next      = rs[9:0] + fv_part;
                            start_time_next = now_reg;
                        end
                    end
                    OP_SET_DIR:
                    begin
                        if (dir_reg == dir_in_reg)
                            flag_next = 1'b1;
                        else if (dir_ok)
                        begin
                            dir_next        = dir_in_reg;
                            frame_next      = rs[9:0];
                            start_time_next = now_reg;
                        end
                    end
                    OP_SET_DIR64:
                    begin
                        if (dir_reg == aux_reg[5:0])
                            flag_next = 1'b1;
                        else
                        begin
                            dir_next        = aux_reg[5:0];
                            frame_next      = rs[9:0];
                            start_time_next = now_reg;
                        end
                    end
                    OP_DIR_START:
                    begin
                        flag_next       = 1'b1;
                        frame_next      = rs[9:0];
                        start_time_next = now_reg;
                    end
                    OP_DIR_END:
                    begin
                        flag_next  = 1'b1;
                        frame_next = re[9:0];
                    end
                    default:
                        flag_next = 1'b0;
                endcase
                state_next = S_OUT;
            end

            S_OUT:
            begin
                // result goes out once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                   = 1'b1;
                    out_data_next.current_frame      = frame_reg;
                    out_data_next.current_direction  = dir_reg;
                    out_data_next.frame_in_direction = frame_reg - rs[9:0];
                    out_data_next.at_last_frame      = (frame_reg == re[9:0]);
                    out_data_next.flag               = flag_reg;
                    state_next                       = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in flight");

    a_apply_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |=> (state_reg == S_OUT))
        else $error("state update not followed by result stage");

    a_heading_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QMOD && div_rsp.done) |=> (aux_reg < {4'b0, cfg.eff_dirs}))
        else $error("quantized heading outside direction count");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DISPATCH) |-> (run_reg != 11'd0))
        else $error("run length is zero");
`endif

endmodule

// ===== hdl/safs_cfg.sv =====
// configuration registers of the sprite frame sequencer and their clamped effective values
// depends on safs_pkg

module safs_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output safs_pkg::safs_cfg_t cfg
);
    import safs_pkg::*;

    logic [10:0] total_frames_reg;
    logic [6:0]  total_directions_reg;
    logic [31:0] frame_interval_reg;
    logic        sprite_loaded_reg;

    logic [6:0]  dirs;
    logic [10:0] frames_lo;
    logic [16:0] frames_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_frames_reg     <= 11'd1;
            total_directions_reg <= 7'd1;
            frame_interval_reg   <= 32'd1;
            sprite_loaded_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TOTAL_FRAMES:     total_frames_reg     <= cfg_data[10:0];
                REG_TOTAL_DIRECTIONS: total_directions_reg <= cfg_data[6:0];
                REG_FRAME_INTERVAL:   frame_interval_reg   <= cfg_data;
                REG_SPRITE_LOADED:    sprite_loaded_reg    <= cfg_data[0];
                default:              sprite_loaded_reg    <= sprite_loaded_reg;
            endcase
        end
    end

    always_comb
    begin
        if (total_directions_reg == 7'd0)
            dirs = 7'd1;
        else if (total_directions_reg > 7'(MAX_DIRECTIONS))
            dirs = 7'(MAX_DIRECTIONS);
        else
            dirs = total_directions_reg;

        // at least one frame per direction, at most the store size
        frames_lo   = (total_frames_reg < {4'b0, dirs}) ? {4'b0, dirs} : total_frames_reg;
        frames_wide = (17'(frames_lo) > 17'(MAX_FRAMES)) ? 17'(MAX_FRAMES) : 17'(frames_lo);

        cfg.eff_frames = frames_wide[10:0];
        cfg.eff_dirs   = dirs;
        cfg.interval   = (frame_interval_reg == 32'd0) ? 32'd1 : frame_interval_reg;
        cfg.loaded     = sprite_loaded_reg;
    end

endmodule

// ===== hdl/safs_div.sv =====
// shared restoring divider, one quotient bit per cycle, DIV_QW steps per division
// depends on safs_pkg; the caller keeps num_hi below den

module safs_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  safs_pkg::safs_div_req_t req,
    output safs_pkg::safs_div_rsp_t rsp
);
    import safs_pkg::*;

    localparam int unsigned CW = $clog2(DIV_QW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       den_reg;
    logic [DIV_QW-1:0] quo_reg;

    logic [32:0]       shifted;
    logic [32:0]       diff;
    logic [31:0]       rem_step;
    logic [DIV_QW-1:0] quo_step;
    logic              qbit;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_QW-1]};
        diff    = shifted - {1'b0, den_reg};
        qbit    = ~diff[32];
        rem_step = qbit ? diff[31:0] : shifted[31:0];
        quo_step = {quo_reg[DIV_QW-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIV_QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            rem_reg <= req.num_hi;
            quo_reg <= req.num_lo;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule
